/* rtl/mxwdp_pkg.sv */
package mxwdp_pkg;

    localparam int SigW = 28;
    localparam int ExpW = 12;

    localparam logic [31:0] CanonNan = 32'h7FC0_0000;
    localparam logic [31:0] InfBits  = 32'h7F80_0000;
    localparam logic [7:0]  ScaleNan = 8'hFF;
    localparam logic [7:0]  ExpMax   = 8'hFF;
    localparam logic [3:0]  NibbleMask = 4'hF;
    localparam int          HighShift  = 4;

    typedef struct packed {
        logic [31:0] prod_lo;
        logic [31:0] prod_hi;
        logic        last;
    } t_pair;

    // Normalize and round sig * 2^x to fp32, round to nearest even, subnormals kept.
    // sig must be nonzero.
    function automatic logic [31:0] round_pack(input logic sgn, input logic [SigW-1:0] sig,
                                               input logic signed [ExpW-1:0] x);
        int                 lead;
        int                 t;
        int                 s;
        logic [SigW+31:0]   ext;
        logic [SigW-1:0]    q;
        logic [31:0]        r;
        logic signed [63:0] val;
        logic [31:0]        res;
        lead = 0;
        for (int i = 0; i < SigW; i++) begin
            if (sig[i]) lead = i;
        end
        t = int'(x) + lead - 23;
        if (t < -149) t = -149;
        s = t - int'(x);
        if (s <= 0) begin
            q = sig << (-s);
            r = '0;
        end else begin
            if (s > 32) s = 32;
            ext = {sig, 32'b0} >> s;
            q = ext[SigW+31:32];
            r = ext[31:0];
        end
        if (r[31] && ((|r[30:0]) || q[0])) q = q + 1'b1;
        val = 64'(longint'(t + 149) * 64'sd8388608) + 64'(q);
        if (val >= 64'sh7F80_0000) res = {sgn, InfBits[30:0]};
        else res = {sgn, val[30:0]};
        return res;
    endfunction

    // act times E2M1 code scaled by 2^(scale-127), one rounding.
    function automatic logic [31:0] weight_product(input logic [31:0] act,
                                                   input logic [3:0] code,
                                                   input logic [7:0] scale);
        logic                  sgn;
        logic [2:0]            m;
        logic [7:0]            ae;
        logic [22:0]           af;
        int                    k;
        logic [1:0]            mw;
        logic                  act_nan, act_inf, act_zero, w_zero, w_inf;
        logic [SigW-1:0]       sig;
        int                    ea;
        logic [31:0]           res;
        sgn = act[31] ^ code[3];
        m   = code[2:0];
        ae  = act[30:23];
        af  = act[22:0];
        case (m)
            3'd1: begin k = -1; mw = 2'd2; end
            3'd2: begin k = 0;  mw = 2'd2; end
            3'd3: begin k = 0;  mw = 2'd3; end
            3'd4: begin k = 1;  mw = 2'd2; end
            3'd5: begin k = 1;  mw = 2'd3; end
            3'd6: begin k = 2;  mw = 2'd2; end
            3'd7: begin k = 2;  mw = 2'd3; end
            default: begin k = 0; mw = 2'd2; end
        endcase
        act_nan  = (ae == ExpMax) && (af != '0);
        act_inf  = (ae == ExpMax) && (af == '0);
        act_zero = (ae == '0) && (af == '0);
        w_zero   = (m == '0);
        w_inf    = !w_zero && ((int'(scale) + k) >= 255);
        sig = '0;
        ea  = (ae == '0) ? 1 : int'(ae);
        if (act_nan || (scale == ScaleNan)) res = CanonNan;
        else if (w_inf) res = act_zero ? CanonNan : {sgn, InfBits[30:0]};
        else if (w_zero) res = act_inf ? CanonNan : {sgn, 31'b0};
        else if (act_inf) res = {sgn, InfBits[30:0]};
        else if (act_zero) res = {sgn, 31'b0};
        else begin
            sig = SigW'({(ae != '0), af}) * SigW'(mw);
            res = round_pack(sgn, sig, ExpW'(ea + int'(scale) + k - 278));
        end
        return res;
    endfunction

    // fp32 add, round to nearest even, NaN results canonical.
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic              sa, sb, sbig, ssml;
        logic [7:0]        ae, be;
        logic [23:0]       ma, mb, mbig, msml;
        int                xa, xb, xbig, d;
        logic [SigW+31:0]  sh;
        logic [SigW-1:0]   big_ext, sml_ext, sum;
        logic              sgn;
        logic [31:0]       res;
        sa = a[31];
        sb = b[31];
        ae = a[30:23];
        be = b[30:23];
        ma = {(ae != '0), a[22:0]};
        mb = {(be != '0), b[22:0]};
        xa = ((ae == '0) ? 1 : int'(ae)) - 150;
        xb = ((be == '0) ? 1 : int'(be)) - 150;
        if (xa >= xb) begin
            sbig = sa; mbig = ma; xbig = xa; ssml = sb; msml = mb; d = xa - xb;
        end else begin
            sbig = sb; mbig = mb; xbig = xb; ssml = sa; msml = ma; d = xb - xa;
        end
        if (d > 30) d = 30;
        big_ext = {1'b0, mbig, 3'b0};
        sh      = {1'b0, msml, 3'b0, 32'b0} >> d;
        sml_ext = sh[SigW+31:32] | SigW'(|sh[31:0]);
        if (sbig == ssml) begin
            sum = big_ext + sml_ext;
            sgn = sbig;
        end else if (big_ext >= sml_ext) begin
            sum = big_ext - sml_ext;
            sgn = sbig;
        end else begin
            sum = sml_ext - big_ext;
            sgn = ssml;
        end
        if (((ae == ExpMax) && (a[22:0] != '0)) || ((be == ExpMax) && (b[22:0] != '0)))
            res = CanonNan;
        else if ((ae == ExpMax) && (be == ExpMax))
            res = (sa != sb) ? CanonNan : a;
        else if (ae == ExpMax) res = a;
        else if (be == ExpMax) res = b;
        else if ((ma == '0) && (mb == '0)) res = {sa & sb, 31'b0};
        else if (sum == '0) res = '0;
        else res = round_pack(sgn, sum, ExpW'(xbig - 3));
        return res;
    endfunction

endpackage

/* rtl/mxfp4_weight_dot_product.sv */
// row_sum is registered after the lane product registers, the low-lane addition and the
// high-lane addition of the row's last item. The single fp32 adder of the accumulator adds
// the low-lane and then the high-lane product, so it takes an item only after both additions.
// Reset (synchronous, active low) clears the accumulator to positive zero and
// empties the product stage and the output register.
module mxfp4_weight_dot_product (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] weight_byte, [15:8] block_scale, [47:16] act_low, [79:48] act_high
    input  logic [79:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] row_sum
    output logic [31:0] o_m_axis_tdata
);

    logic             accept;
    logic             pair_valid;
    logic             pair_last;
    logic             merge_ready;
    logic [7:0]       wbyte;
    logic [7:0]       scale;
    mxwdp_pkg::t_pair pair;

    assign wbyte  = i_s_axis_tdata[7:0];
    assign scale  = i_s_axis_tdata[15:8];
    assign o_s_axis_tready = !pair_valid || merge_ready;
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    mxwdp_lane u_lane_lo (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_act   (i_s_axis_tdata[47:16]),
        .i_code  (wbyte[3:0] & mxwdp_pkg::NibbleMask),
        .i_scale (scale),
        .o_prod  (pair.prod_lo)
    );

    mxwdp_lane u_lane_hi (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_act   (i_s_axis_tdata[79:48]),
        .i_code  (4'(wbyte >> mxwdp_pkg::HighShift) & mxwdp_pkg::NibbleMask),
        .i_scale (scale),
        .o_prod  (pair.prod_hi)
    );

    mxwdp_pair_reg u_pair (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_last   (i_s_axis_tlast),
        .i_taken  (merge_ready),
        .o_valid  (pair_valid),
        .o_last   (pair_last)
    );

    assign pair.last = pair_last;

    mxwdp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pair_valid),
        .i_pair  (pair),
        .o_ready (merge_ready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_sum   (o_m_axis_tdata)
    );

endmodule

/* rtl/mxwdp_lane.sv */
module mxwdp_lane (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_act,
    input  logic [3:0]  i_code,
    input  logic [7:0]  i_scale,
    output logic [31:0] o_prod
);

    logic [31:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= mxwdp_pkg::weight_product(i_act, i_code, i_scale);
        end
    end

    assign o_prod = r_prod;

endmodule

/* rtl/mxwdp_merge.sv */
module mxwdp_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mxwdp_pkg::t_pair  i_pair,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_sum
);

    logic        r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_hi, n_hi;
    logic        r_last, n_last;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data, n_out_data;
    logic [31:0] sum;
    logic        out_free;

    assign o_ready  = !r_phase;
    assign out_free = !r_out_valid || i_ready;
    assign sum      = mxwdp_pkg::fp_add(r_acc, r_phase ? r_hi : i_pair.prod_lo);

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_hi        = r_hi;
        n_last      = r_last;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_ready;
        if (!r_phase) begin
            if (i_valid) begin
                n_acc   = sum;
                n_hi    = i_pair.prod_hi;
                n_last  = i_pair.last;
                n_phase = 1'b1;
            end
        end else if (!r_last || out_free) begin
            // second addition; on a row end send the sum and clear
            n_phase = 1'b0;
            if (r_last) begin
                n_out_data  = sum;
                n_out_valid = 1'b1;
                n_acc       = '0;
            end else begin
                n_acc = sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
        r_hi       <= n_hi;
        r_last     <= n_last;
        r_out_data <= n_out_data;
    end

    assign o_valid = r_out_valid;
    assign o_sum   = r_out_data;

endmodule

/* rtl/mxwdp_lane_top_unused.sv */
module mxwdp_pair_reg (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  logic  i_last,
    input  logic  i_taken,
    output logic  o_valid,
    output logic  o_last
);

    logic r_valid;
    logic r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_taken) begin
            r_valid <= 1'b0;
        end
        if (i_accept) begin
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;

endmodule
